@@ src/tilt_sensor_supervisor_fsm_unit_macros.svh @@
// Assertion macros for the tilt sensor supervisor.
`ifndef TILT_SENSOR_SUPERVISOR_FSM_UNIT_MACROS_SVH
`define TILT_SENSOR_SUPERVISOR_FSM_UNIT_MACROS_SVH
`ifndef SYNTH
`define TSS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TSS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSS_ASSERT(label, clk, rst, prop, msg)
`define TSS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ src/tss_pkg.sv @@
// Package: codes, table and shared types of the tilt sensor supervisor.
`timescale 1ns / 1ps
package tss_pkg;
  localparam int TABLE_ENTRIES = 12;
  localparam int MAX_CLOCK_PULSES = 9;

  localparam logic [3:0] PH_ID = 4'd0;
  localparam logic [3:0] PH_WRITE = 4'd1;
  localparam logic [3:0] PH_VERIFY = 4'd2;
  localparam logic [3:0] PH_POLL = 4'd3;
  localparam logic [3:0] PH_COOL = 4'd4;
  localparam logic [3:0] PH_RELEASE = 4'd5;
  localparam logic [3:0] PH_CLK_LOW = 4'd6;
  localparam logic [3:0] PH_CLK_HIGH = 4'd7;
  localparam logic [3:0] PH_STOP_LOW = 4'd8;
  localparam logic [3:0] PH_STOP_CLK = 4'd9;
  localparam logic [3:0] PH_STOP_DATA = 4'd10;
  localparam logic [3:0] PH_RESTORE = 4'd11;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_READ = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_PIN = 3'd3;
  localparam logic [2:0] ACT_INIT = 3'd4;

  localparam logic [2:0] CFG_THS = 3'd0;
  localparam logic [2:0] CFG_POLL = 3'd1;
  localparam logic [2:0] CFG_FRESH = 3'd2;
  localparam logic [2:0] CFG_RETRY = 3'd3;
  localparam logic [2:0] CFG_AUDIT = 3'd4;
  localparam logic [2:0] CFG_EDGE = 3'd5;

  localparam logic [7:0] REG_WHO = 8'h0F;
  localparam logic [7:0] DEV_ID = 8'h33;
  localparam logic [7:0] REG_INT_SRC = 8'h31;
  localparam logic [7:0] AUTO_INC = 8'h80;
  localparam logic [7:0] TILT_MASK = 8'h50;
  localparam logic [3:0] THS_SLOT = 4'd6;

  typedef struct packed {
    logic [6:0]  tilt_threshold;
    logic [15:0] poll_period_ms;
    logic [15:0] fresh_limit_ms;
    logic [15:0] retry_delay_ms;
    logic [15:0] audit_interval_ms;
    logic [7:0]  edge_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        xfer_ok;
    logic [7:0]  read_value;
    logic        scl_level;
    logic        sda_level;
    logic        init_ok;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  reg_addr;
    logic [7:0]  write_data;
    logic        scl_release;
    logic        sda_release;
    logic        fault_event;
    logic        healthy;
    logic        tilt_alarm;
    logic [31:0] fault_total;
  } result_t;

  function automatic logic [3:0] entry_index(input logic [3:0] pos);
    return (pos < 4'(TABLE_ENTRIES)) ? pos : 4'(TABLE_ENTRIES - 1);
  endfunction

  function automatic logic [7:0] entry_reg(input logic [3:0] pos);
    logic [7:0] r;
    case (entry_index(pos))
      4'd0: r = 8'h22;  4'd1: r = 8'h20;  4'd2: r = 8'h21;  4'd3: r = 8'h23;
      4'd4: r = 8'h1F;  4'd5: r = 8'h24;  4'd6: r = 8'h32;  4'd7: r = 8'h33;
      4'd8: r = 8'h30;  4'd9: r = 8'h25;  4'd10: r = 8'h2E; default: r = 8'h22;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] entry_val(input logic [3:0] pos, input logic [6:0] ths);
    logic [7:0] v;
    case (entry_index(pos))
      4'd1: v = 8'h57;
      4'd3: v = 8'h88;
      4'd4: v = 8'hC0;
      THS_SLOT: v = {1'b0, ths};
      4'd7: v = 8'h01;
      4'd8: v = 8'h10;
      4'd11: v = 8'h40;
      default: v = 8'h00;
    endcase
    return v;
  endfunction
endpackage

@@ src/tss_cfg_regs.sv @@
// Configuration register file of the tilt sensor supervisor.
`timescale 1ns / 1ps
module tss_cfg_regs import tss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{tilt_threshold: 7'd16, poll_period_ms: 16'd10, fresh_limit_ms: 16'd100,
               retry_delay_ms: 16'd1000, audit_interval_ms: 16'd1000, edge_delay_ms: 8'd1};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THS:   cfg.tilt_threshold <= cfg_data[6:0];
        CFG_POLL:  cfg.poll_period_ms <= cfg_data;
        CFG_FRESH: cfg.fresh_limit_ms <= cfg_data;
        CFG_RETRY: cfg.retry_delay_ms <= cfg_data;
        CFG_AUDIT: cfg.audit_interval_ms <= cfg_data;
        CFG_EDGE:  cfg.edge_delay_ms <= cfg_data[7:0];
        default: ;
      endcase
    end
  end
endmodule

@@ src/tss_core.sv @@
// Supervisor state and one-pass next-state logic.
`timescale 1ns / 1ps
module tss_core import tss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  cfg_t    cfg,
  input  item_t   item,
  output result_t res
);
  `include "tilt_sensor_supervisor_fsm_unit_macros.svh"

  logic [3:0]  phase, table_pos, audit_pos, clock_pulses;
  logic        poll_just_done, in_recovery, sample_valid, sample_tilt;
  logic [31:0] phase_time, last_poll_time, audit_start_time, sample_time, fault_count;

  logic [3:0]  phase_next, table_pos_next, audit_pos_next, clock_pulses_next;
  logic        poll_just_done_next, in_recovery_next, sample_valid_next, sample_tilt_next;
  logic [31:0] phase_time_next, last_poll_time_next, audit_start_time_next;
  logic [31:0] sample_time_next, fault_count_next;

  logic [31:0] now;
  logic        ok, waited, flt, hl;
  logic [3:0]  ph, pos_inc;
  logic [7:0]  exp_val, a_reg, a_exp;

  always_comb begin
    now = item.now_ms;
    ok = item.xfer_ok & item.scl_level & item.sda_level;
    waited = (now - phase_time) >= {24'd0, cfg.edge_delay_ms};
    ph = (phase > PH_RESTORE) ? PH_ID : phase;
    exp_val = entry_val(table_pos, cfg.tilt_threshold);
    a_reg = (audit_pos != 4'd0) ? entry_reg(audit_pos) : REG_WHO;
    a_exp = (audit_pos != 4'd0) ? entry_val(audit_pos, cfg.tilt_threshold) : DEV_ID;
    pos_inc = 4'd0;
    flt = 1'b0;

    phase_next = ph; table_pos_next = table_pos; audit_pos_next = audit_pos;
    clock_pulses_next = clock_pulses; poll_just_done_next = poll_just_done;
    in_recovery_next = in_recovery; sample_valid_next = sample_valid;
    sample_tilt_next = sample_tilt; phase_time_next = phase_time;
    last_poll_time_next = last_poll_time; audit_start_time_next = audit_start_time;
    sample_time_next = sample_time;

    res = '0;
    res.action = ACT_NONE;
    res.scl_release = 1'b1;
    res.sda_release = 1'b1;

    if (sample_valid && ((now - sample_time) > {16'd0, cfg.fresh_limit_ms})) begin
      flt = 1'b1;
    end else begin
      case (ph)
        PH_WRITE: begin
          res.action = ACT_WRITE;
          res.reg_addr = entry_reg(table_pos) | AUTO_INC;
          res.write_data = exp_val;
          if (!ok) flt = 1'b1; else phase_next = PH_VERIFY;
        end
        PH_VERIFY: begin
          res.action = ACT_READ;
          res.reg_addr = entry_reg(table_pos) | AUTO_INC;
          if (!ok || item.read_value != exp_val) flt = 1'b1;
          else begin
            pos_inc = table_pos + 4'd1;
            table_pos_next = pos_inc;
            if (pos_inc >= 4'(TABLE_ENTRIES)) begin
              phase_next = PH_POLL;
              last_poll_time_next = now - {16'd0, cfg.poll_period_ms};
            end else phase_next = PH_WRITE;
          end
        end
        PH_POLL: begin
          if (poll_just_done && ((now - audit_start_time) >= {16'd0, cfg.audit_interval_ms}))
          begin
            poll_just_done_next = 1'b0;
            res.action = ACT_READ;
            res.reg_addr = a_reg | AUTO_INC;
            if (!ok || item.read_value != a_exp) flt = 1'b1;
            else begin
              pos_inc = audit_pos + 4'd1;
              if (pos_inc >= 4'(TABLE_ENTRIES)) begin
                audit_pos_next = 4'd0;
                audit_start_time_next = now;
              end else audit_pos_next = pos_inc;
            end
          end else if ((now - last_poll_time) >= {16'd0, cfg.poll_period_ms}) begin
            last_poll_time_next = now;
            res.action = ACT_READ;
            res.reg_addr = REG_INT_SRC | AUTO_INC;
            if (!ok) flt = 1'b1;
            else begin
              sample_tilt_next = (item.read_value & TILT_MASK) == TILT_MASK;
              sample_time_next = now;
              sample_valid_next = 1'b1;
              poll_just_done_next = 1'b1;
              in_recovery_next = 1'b0;
            end
          end
        end
        PH_COOL: begin
          if ((now - phase_time) >= {16'd0, cfg.retry_delay_ms}) begin
            in_recovery_next = 1'b1;
            res.action = ACT_PIN;
            clock_pulses_next = 4'd0;
            phase_time_next = now;
            phase_next = PH_RELEASE;
          end
        end
        PH_RELEASE, PH_CLK_HIGH: begin
          if (waited) begin
            res.action = ACT_PIN;
            if (!item.scl_level) flt = 1'b1;
            else if (item.sda_level) begin
              res.scl_release = 1'b0; res.sda_release = 1'b0;
              phase_next = PH_STOP_LOW; phase_time_next = now;
            end else if (clock_pulses < 4'(MAX_CLOCK_PULSES)) begin
              res.scl_release = 1'b0;
              phase_next = PH_CLK_LOW; phase_time_next = now;
            end else flt = 1'b1;
          end
        end
        PH_CLK_LOW: begin
          if (waited) begin
            res.action = ACT_PIN;
            clock_pulses_next = clock_pulses + 4'd1;
            phase_next = PH_CLK_HIGH; phase_time_next = now;
          end
        end
        PH_STOP_LOW: begin
          if (waited) begin
            res.action = ACT_PIN;
            res.sda_release = 1'b0;
            phase_next = PH_STOP_CLK; phase_time_next = now;
          end
        end
        PH_STOP_CLK: begin
          if (waited) begin
            res.action = ACT_PIN;
            if (!item.scl_level) flt = 1'b1;
            else begin phase_next = PH_STOP_DATA; phase_time_next = now; end
          end
        end
        PH_STOP_DATA: begin
          if (waited) begin
            if (!item.scl_level || !item.sda_level) begin
              res.action = ACT_PIN; flt = 1'b1;
            end else phase_next = PH_RESTORE;
          end
        end
        PH_RESTORE: begin
          res.action = ACT_INIT;
          if (!item.init_ok) flt = 1'b1; else phase_next = PH_ID;
        end
        default: begin
          res.action = ACT_READ;
          res.reg_addr = REG_WHO | AUTO_INC;
          if (!ok || item.read_value != DEV_ID) flt = 1'b1;
          else begin
            table_pos_next = 4'd0; audit_pos_next = 4'd0;
            audit_start_time_next = now;
            poll_just_done_next = 1'b0; phase_next = PH_WRITE;
          end
        end
      endcase
    end

    fault_count_next = fault_count;
    if (flt) begin
      sample_valid_next = 1'b0;
      fault_count_next = fault_count + 32'd1;
      phase_next = PH_COOL;
      phase_time_next = now;
    end
    hl = sample_valid_next && ((now - sample_time_next) <= {16'd0, cfg.fresh_limit_ms});
    res.fault_event = flt;
    res.healthy = hl;
    res.tilt_alarm = !hl || sample_tilt_next;
    res.fault_total = fault_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ID; table_pos <= '0; audit_pos <= '0; clock_pulses <= '0;
      poll_just_done <= 1'b0; in_recovery <= 1'b0; sample_valid <= 1'b0;
      sample_tilt <= 1'b0; phase_time <= '0; last_poll_time <= '0;
      audit_start_time <= '0; sample_time <= '0; fault_count <= '0;
    end else if (step) begin
      phase <= phase_next; table_pos <= table_pos_next; audit_pos <= audit_pos_next;
      clock_pulses <= clock_pulses_next; poll_just_done <= poll_just_done_next;
      in_recovery <= in_recovery_next; sample_valid <= sample_valid_next;
      sample_tilt <= sample_tilt_next; phase_time <= phase_time_next;
      last_poll_time <= last_poll_time_next; audit_start_time <= audit_start_time_next;
      sample_time <= sample_time_next; fault_count <= fault_count_next;
    end
  end

  `TSS_ASSERT(a_fault_cool, clk, rst, (step && flt) |=> (phase == PH_COOL), "fault must enter cooldown")
  `TSS_ASSERT(a_fault_cnt, clk, rst, (step && flt) |=> (fault_count == $past(fault_count) + 32'd1), "fault count must advance")
  `TSS_ASSERT(a_pulses, clk, rst, clock_pulses <= 4'(MAX_CLOCK_PULSES), "too many clock pulses")
  `TSS_ASSERT(a_recov_poll, clk, rst, (in_recovery && sample_valid) |-> 1'b0 || !in_recovery || !sample_valid, "recovery with valid sample")
endmodule

@@ src/tilt_sensor_supervisor_fsm_unit.sv @@
// Top level of the tilt sensor supervisor.
`timescale 1ns / 1ps
// One service pass per beat: every accepted input beat runs the whole supervisor
// step (identity check, table write and read-back, polling with rolling audit,
// cooldown, nine-pulse bus recovery, re-init) in combinational logic between the
// input register and the result register, so a new beat can be taken every cycle
// while the output does not stall. Each result beat is registered in the result
// register from the beat held in the input register. The result register and its
// stall decouple the two sides; input stall is only raised when both the working
// stage and the result register are full and the output stalls.
module tilt_sensor_supervisor_fsm_unit import tss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ms,
  input  logic        xfer_ok,
  input  logic [7:0]  read_value,
  input  logic        scl_level,
  input  logic        sda_level,
  input  logic        init_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [7:0]  reg_addr,
  output logic [7:0]  write_data,
  output logic        scl_release,
  output logic        sda_release,
  output logic        fault_event,
  output logic        healthy,
  output logic        tilt_alarm,
  output logic [31:0] fault_total,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  `include "tilt_sensor_supervisor_fsm_unit_macros.svh"

  cfg_t    cfg;
  item_t   item;
  result_t res, out_reg;
  logic    item_valid, step, out_free;

  tss_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  // Advance the working stage whenever the result register can take its beat.
  assign out_free = !out_valid || !out_stall;
  assign step = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  tss_core u_core (
    .clk(clk), .rst(rst), .step(step), .cfg(cfg), .item(item), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= '{now_ms, xfer_ok, read_value, scl_level, sda_level, init_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  // Hold the result beat while stalled.
  always_ff @(posedge clk) begin
    if (step) out_reg <= res;
  end

  assign action = out_reg.action;
  assign reg_addr = out_reg.reg_addr;
  assign write_data = out_reg.write_data;
  assign scl_release = out_reg.scl_release;
  assign sda_release = out_reg.sda_release;
  assign fault_event = out_reg.fault_event;
  assign healthy = out_reg.healthy;
  assign tilt_alarm = out_reg.tilt_alarm;
  assign fault_total = out_reg.fault_total;

  `TSS_ASSERT(a_no_loss, clk, rst, (out_valid && out_stall) |=> out_valid, "result beat dropped")
  `TSS_ASSERT(a_step_free, clk, rst, step |-> out_free, "step into full result register")
  `TSS_ASSERT_RST(a_rst_clear, clk, $past(rst) |-> !out_valid, "result valid after reset")
endmodule

@@ dv/tilt_sensor_supervisor_fsm_unit_tb.sv @@
// Testbench for the tilt sensor supervisor: directed and random service passes checked against a predictor.
`timescale 1ns / 1ps
module tilt_sensor_supervisor_fsm_unit_tb;
  import tss_pkg::*;

  // Supervisor state as the predictor tracks it.
  typedef struct {
    logic [3:0]  phase;
    logic [3:0]  tbl_pos;
    logic [3:0]  aud_pos;
    logic [3:0]  pulses;
    bit          polled;
    bit          recovering;
    bit          smp_valid;
    bit          smp_tilt;
    logic [31:0] phase_t;
    logic [31:0] poll_t;
    logic [31:0] audit_t;
    logic [31:0] smp_t;
    logic [31:0] faults;
  } sup_state_t;

  // Sensor configuration table: register addresses and values (slot 6 is the threshold).
  localparam logic [7:0] TBL_REG [12] = '{8'h22, 8'h20, 8'h21, 8'h23, 8'h1F, 8'h24,
                                         8'h32, 8'h33, 8'h30, 8'h25, 8'h2E, 8'h22};
  localparam logic [7:0] TBL_VAL [12] = '{8'h00, 8'h57, 8'h00, 8'h88, 8'hC0, 8'h00,
                                         8'h00, 8'h01, 8'h10, 8'h00, 8'h00, 8'h40};
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] now_ms;
  logic        xfer_ok;
  logic [7:0]  read_value;
  logic        scl_level;
  logic        sda_level;
  logic        init_ok;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  action;
  logic [7:0]  reg_addr;
  logic [7:0]  write_data;
  logic        scl_release;
  logic        sda_release;
  logic        fault_event;
  logic        healthy;
  logic        tilt_alarm;
  logic [31:0] fault_total;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  tilt_sensor_supervisor_fsm_unit i_dut (.*);

  item_t      pass_q [$];     // passes waiting to be driven
  result_t    action_q [$];   // predicted results waiting for the output
  item_t      cur_pass;
  sup_state_t live_st;        // predictor state, advanced on accepted beats
  sup_state_t gen_st;         // look-ahead copy used to shape well-formed responses
  cfg_t       cfg;
  logic [31:0] gen_now;
  bit          quiet;
  bit          hold_req;
  int          hold_cnt;
  int          errors;
  int          idle_cycles;

  function automatic logic [3:0] slot_of(input logic [3:0] pos);
    return (pos < 4'd12) ? pos : 4'd11;
  endfunction

  function automatic logic [7:0] slot_val(input logic [3:0] pos, input cfg_t c);
    logic [3:0] i;
    i = slot_of(pos);
    return (i == THS_SLOT) ? {1'b0, c.tilt_threshold} : TBL_VAL[i];
  endfunction

  function automatic void take_fault(inout sup_state_t s, inout result_t r,
                                     input logic [31:0] now);
    s.smp_valid = 1'b0;
    s.faults = s.faults + 32'd1;
    s.phase = PH_COOL;
    s.phase_t = now;
    r.fault_event = 1'b1;
  endfunction

  function automatic void ask(inout result_t r, input logic [2:0] act,
                              input logic [7:0] rg, input logic [7:0] data);
    r.action = act;
    r.reg_addr = rg | AUTO_INC;
    r.write_data = data;
  endfunction

  function automatic void drive_pins(inout result_t r, input logic scl, input logic sda);
    r.action = ACT_PIN;
    r.scl_release = scl;
    r.sda_release = sda;
  endfunction

  // One service pass of the supervisor.
  function automatic result_t supervise(inout sup_state_t s, input cfg_t c, input item_t it);
    result_t     r;
    logic [31:0] now;
    logic [31:0] ag;
    logic [7:0]  rg;
    logic [7:0]  want;
    bit          ok;
    bit          waited;
    bit          hl;
    r = '0;
    r.action = ACT_NONE;
    r.scl_release = 1'b1;
    r.sda_release = 1'b1;
    now = it.now_ms;
    ok = it.xfer_ok && it.scl_level && it.sda_level;
    ag = now - s.phase_t;
    waited = ag >= {24'd0, c.edge_delay_ms};
    if (s.phase > PH_RESTORE) s.phase = PH_ID;

    if (s.smp_valid && (now - s.smp_t) > {16'd0, c.fresh_limit_ms}) begin
      take_fault(s, r, now);   // stale sample
    end else begin
      case (s.phase)
        PH_ID: begin
          ask(r, ACT_READ, REG_WHO, 8'd0);
          if (!ok || it.read_value != DEV_ID) take_fault(s, r, now);
          else begin
            s.tbl_pos = 4'd0; s.aud_pos = 4'd0; s.audit_t = now;
            s.polled = 1'b0; s.phase = PH_WRITE;
          end
        end
        PH_WRITE: begin
          ask(r, ACT_WRITE, TBL_REG[slot_of(s.tbl_pos)], slot_val(s.tbl_pos, c));
          if (!ok) take_fault(s, r, now); else s.phase = PH_VERIFY;
        end
        PH_VERIFY: begin
          ask(r, ACT_READ, TBL_REG[slot_of(s.tbl_pos)], 8'd0);
          if (!ok || it.read_value != slot_val(s.tbl_pos, c)) take_fault(s, r, now);
          else begin
            s.tbl_pos = s.tbl_pos + 4'd1;
            if (s.tbl_pos >= 4'd12) begin
              s.phase = PH_POLL;
              s.poll_t = now - {16'd0, c.poll_period_ms};
            end else s.phase = PH_WRITE;
          end
        end
        PH_POLL: begin
          if (s.polled && (now - s.audit_t) >= {16'd0, c.audit_interval_ms}) begin
            rg = (s.aud_pos != 4'd0) ? TBL_REG[slot_of(s.aud_pos)] : REG_WHO;
            want = (s.aud_pos != 4'd0) ? slot_val(s.aud_pos, c) : DEV_ID;
            s.polled = 1'b0;
            ask(r, ACT_READ, rg, 8'd0);
            if (!ok || it.read_value != want) take_fault(s, r, now);
            else begin
              s.aud_pos = s.aud_pos + 4'd1;
              if (s.aud_pos >= 4'd12) begin
                s.aud_pos = 4'd0; s.audit_t = now;
              end
            end
          end else if ((now - s.poll_t) >= {16'd0, c.poll_period_ms}) begin
            s.poll_t = now;
            ask(r, ACT_READ, REG_INT_SRC, 8'd0);
            if (!ok) take_fault(s, r, now);
            else begin
              s.smp_tilt = (it.read_value & TILT_MASK) == TILT_MASK;
              s.smp_t = now;
              s.smp_valid = 1'b1;
              s.polled = 1'b1;
              s.recovering = 1'b0;
            end
          end
        end
        PH_COOL: begin
          if (ag >= {16'd0, c.retry_delay_ms}) begin
            s.recovering = 1'b1;
            drive_pins(r, 1'b1, 1'b1);
            s.pulses = 4'd0; s.phase_t = now; s.phase = PH_RELEASE;
          end
        end
        PH_RELEASE, PH_CLK_HIGH: begin
          if (waited) begin
            if (!it.scl_level) begin
              drive_pins(r, 1'b1, 1'b1); take_fault(s, r, now);
            end else if (it.sda_level) begin
              drive_pins(r, 1'b0, 1'b0); s.phase = PH_STOP_LOW; s.phase_t = now;
            end else if (s.pulses < 4'(MAX_CLOCK_PULSES)) begin
              drive_pins(r, 1'b0, 1'b1); s.phase = PH_CLK_LOW; s.phase_t = now;
            end else begin
              drive_pins(r, 1'b1, 1'b1); take_fault(s, r, now);   // bus stuck
            end
          end
        end
        PH_CLK_LOW: begin
          if (waited) begin
            drive_pins(r, 1'b1, 1'b1);
            s.pulses = s.pulses + 4'd1; s.phase = PH_CLK_HIGH; s.phase_t = now;
          end
        end
        PH_STOP_LOW: begin
          if (waited) begin
            drive_pins(r, 1'b1, 1'b0); s.phase = PH_STOP_CLK; s.phase_t = now;
          end
        end
        PH_STOP_CLK: begin
          if (waited) begin
            if (!it.scl_level) begin
              drive_pins(r, 1'b1, 1'b1); take_fault(s, r, now);
            end else begin
              drive_pins(r, 1'b1, 1'b1); s.phase = PH_STOP_DATA; s.phase_t = now;
            end
          end
        end
        PH_STOP_DATA: begin
          if (waited) begin
            if (!it.scl_level || !it.sda_level) begin
              drive_pins(r, 1'b1, 1'b1); take_fault(s, r, now);
            end else s.phase = PH_RESTORE;
          end
        end
        default: begin
          r.action = ACT_INIT;
          if (!it.init_ok) take_fault(s, r, now); else s.phase = PH_ID;
        end
      endcase
    end

    hl = s.smp_valid && (now - s.smp_t) <= {16'd0, c.fresh_limit_ms};
    r.healthy = hl;
    r.tilt_alarm = !hl || s.smp_tilt;
    r.fault_total = s.faults;
    return r;
  endfunction

  function automatic sup_state_t reset_state();
    sup_state_t s;
    s.phase = PH_ID; s.tbl_pos = 4'd0; s.aud_pos = 4'd0; s.pulses = 4'd0;
    s.polled = 1'b0; s.recovering = 1'b0; s.smp_valid = 1'b0; s.smp_tilt = 1'b0;
    s.phase_t = '0; s.poll_t = '0; s.audit_t = '0; s.smp_t = '0; s.faults = '0;
    return s;
  endfunction

  // Build the next pass. Well-formed passes answer what the supervisor will ask,
  // with a few failed transfers and bad bytes mixed in; noise randomizes every field but the time.
  task automatic queue_pass(input bit noise);
    item_t      it;
    sup_state_t probe;
    result_t    r;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) gen_now = gen_now + $urandom_range(0, 3);
    else if (roll < 80) gen_now = gen_now + $urandom_range(0, cfg.edge_delay_ms + 1);
    else if (roll < 88) gen_now = gen_now + $urandom_range(0, cfg.poll_period_ms + 2);
    else if (roll < 96) gen_now = gen_now + $urandom_range(0, cfg.retry_delay_ms + 2);
    else gen_now = $urandom;
    it.now_ms = gen_now;
    if (noise) begin
      it.xfer_ok = 1'($urandom); it.read_value = 8'($urandom); it.scl_level = 1'($urandom);
      it.sda_level = 1'($urandom); it.init_ok = 1'($urandom);
    end else begin
      it.xfer_ok = $urandom_range(0, 99) >= 3;
      it.scl_level = $urandom_range(0, 99) >= 3;
      it.sda_level = 1'b1;
      it.init_ok = $urandom_range(0, 99) >= 5;
      it.read_value = 8'($urandom);
      // Hold SDA low most of the time during recovery to exercise clock pulsing.
      if (gen_st.phase == PH_RELEASE || gen_st.phase == PH_CLK_HIGH)
        it.sda_level = $urandom_range(0, 99) < 25;
      else if (gen_st.phase == PH_STOP_DATA)
        it.sda_level = $urandom_range(0, 99) >= 5;
      probe = gen_st;
      r = supervise(probe, cfg, it);
      if (r.action == ACT_READ && $urandom_range(0, 99) >= 3) begin
        if (r.reg_addr == (REG_WHO | AUTO_INC)) it.read_value = DEV_ID;
        else if (r.reg_addr == (REG_INT_SRC | AUTO_INC)) it.read_value = 8'($urandom);
        else if (gen_st.phase == PH_VERIFY) it.read_value = slot_val(gen_st.tbl_pos, cfg);
        else it.read_value = slot_val(gen_st.aud_pos, cfg);
      end
    end
    r = supervise(gen_st, cfg, it);
    pass_q.push_back(it);
  endtask

  task automatic queue_fixed(input logic [31:0] t, input logic ok, input logic [7:0] rv,
                             input logic scl, input logic sda, input logic ini);
    item_t   it;
    result_t r;
    it.now_ms = t; it.xfer_ok = ok; it.read_value = rv;
    it.scl_level = scl; it.sda_level = sda; it.init_ok = ini;
    gen_now = t;
    r = supervise(gen_st, cfg, it);
    pass_q.push_back(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THS:   cfg.tilt_threshold = data[6:0];
      CFG_POLL:  cfg.poll_period_ms = data;
      CFG_FRESH: cfg.fresh_limit_ms = data;
      CFG_RETRY: cfg.retry_delay_ms = data;
      CFG_AUDIT: cfg.audit_interval_ms = data;
      default:   cfg.edge_delay_ms = data[7:0];
    endcase
  endtask

  // Wait until every pass is driven and every result has come, then let the pipe drain.
  task automatic drain();
    while (pass_q.size() != 0 || action_q.size() != 0 || in_valid) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: advance the predictor on every accepted input beat, then offer the next pass.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) action_q.push_back(supervise(live_st, cfg, cur_pass));
      if (!in_valid || !in_stall) begin
        if (pass_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
          cur_pass = pass_q.pop_front();
          in_valid <= 1'b1;
          now_ms <= cur_pass.now_ms;
          xfer_ok <= cur_pass.xfer_ok;
          read_value <= cur_pass.read_value;
          scl_level <= cur_pass.scl_level;
          sda_level <= cur_pass.sda_level;
          init_ok <= cur_pass.init_ok;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction, then pick the stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (action_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual action %0h",
                   $time, action);
          errors++;
        end else begin
          result_t w;
          w = action_q.pop_front();
          check_field("action", 32'(w.action), 32'(action));
          check_field("reg_addr", 32'(w.reg_addr), 32'(reg_addr));
          check_field("write_data", 32'(w.write_data), 32'(write_data));
          check_field("scl_release", 32'(w.scl_release), 32'(scl_release));
          check_field("sda_release", 32'(w.sda_release), 32'(sda_release));
          check_field("fault_event", 32'(w.fault_event), 32'(fault_event));
          check_field("healthy", 32'(w.healthy), 32'(healthy));
          check_field("tilt_alarm", 32'(w.tilt_alarm), 32'(tilt_alarm));
          check_field("fault_total", w.fault_total, fault_total);
        end
      end
      // A long hold-off lets the block fill up and stall its input.
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        hold_cnt <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 15);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[tilt_sensor_supervisor_fsm_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    now_ms = '0; xfer_ok = 1'b0; read_value = '0;
    scl_level = 1'b1; sda_level = 1'b1; init_ok = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_THS; cfg_data = '0;
    quiet = 0; hold_req = 0; hold_cnt = 0; errors = 0; idle_cycles = 0;
    cfg.tilt_threshold = 7'd16; cfg.poll_period_ms = 16'd10; cfg.fresh_limit_ms = 16'd100;
    cfg.retry_delay_ms = 16'd1000; cfg.audit_interval_ms = 16'd1000; cfg.edge_delay_ms = 8'd1;
    live_st = reset_state();
    gen_st = reset_state();
    gen_now = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, a bad pin during a transfer, then well-formed passes.
    queue_fixed(32'h0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_fixed(32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1);
    queue_fixed(32'h0000_1000, 1'b1, DEV_ID, 1'b0, 1'b1, 1'b1);
    repeat (20) queue_pass(0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;  // reset settings
        1: begin
          write_reg(CFG_THS, 16'd0);    write_reg(CFG_POLL, 16'd1);
          write_reg(CFG_FRESH, 16'd1);  write_reg(CFG_RETRY, 16'd1);
          write_reg(CFG_AUDIT, 16'd1);  write_reg(CFG_EDGE, 16'd0);
        end
        2: begin
          write_reg(CFG_THS, 16'd127);     write_reg(CFG_POLL, 16'hFFFF);
          write_reg(CFG_FRESH, 16'hFFFF);  write_reg(CFG_RETRY, 16'hFFFF);
          write_reg(CFG_AUDIT, 16'hFFFF);  write_reg(CFG_EDGE, 16'd255);
        end
        default: begin
          write_reg(CFG_THS, 16'($urandom_range(0, 127)));
          write_reg(CFG_POLL, 16'($urandom_range(1, 12)));
          write_reg(CFG_FRESH, 16'($urandom_range(1, 60)));
          write_reg(CFG_RETRY, 16'($urandom_range(1, 40)));
          write_reg(CFG_AUDIT, 16'($urandom_range(1, 50)));
          write_reg(CFG_EDGE, 16'($urandom_range(0, 3)));
        end
      endcase
      quiet = (ph == 4);
      for (int n = 0; n < 235; n++) queue_pass($urandom_range(0, 99) < 10);
      if (ph == 3) hold_req = 1;
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) $display("[tilt_sensor_supervisor_fsm_unit] OK");
    else $display("[tilt_sensor_supervisor_fsm_unit] ERROR");
    $finish;
  end
endmodule
